[src/dew_heater_ramp_duty_controller_defines.svh]
// Assertion macros shared by the dew heater duty controller RTL.
// Depends on nothing; the asserting modules provide clk and arst_n.
`ifndef DEW_HEATER_RAMP_DUTY_CONTROLLER_DEFINES_SVH
`define DEW_HEATER_RAMP_DUTY_CONTROLLER_DEFINES_SVH
`ifndef SYNTH
// Checked outside of reset.
`define DHR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define DHR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DHR_ASSERT(label, prop, msg)
`define DHR_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[src/dhr_pkg.sv]
// Shared constants, mode codes and status types of the dew heater duty controller.
// Depends on nothing.
package dhr_pkg;

	localparam int TEMP_BITS_DEF = 12;
	localparam int DUTY_BITS_DEF = 8;

	// Readings below -50 C in 1/16 C count as absent.
	localparam int COLD_LIMIT = -800;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TARGET   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_DEW_OFS  = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_RAMP     = CFG_IDX_W'(5);

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_FIXED  = 2'd1,
		MODE_DEW    = 2'd2,
		MODE_TARGET = 2'd3
	} dhr_mode_t;

	// Status of a serial arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} dhr_stat_t;

endpackage

[src/dhr_in_if.sv]
// Valid/ready channel carrying one control tick of sensor readings.
// Depends on dhr_pkg.
interface dhr_in_if import dhr_pkg::*; #(
	parameter int TEMP_BITS = TEMP_BITS_DEF
) ();
	logic                        valid;
	logic                        ready;
	logic signed [TEMP_BITS-1:0] heater_temp;
	logic                        heater_present;
	logic signed [TEMP_BITS-1:0] ambient_dewpoint;
	logic                        ambient_present;

	modport source (
		output valid, heater_temp, heater_present, ambient_dewpoint, ambient_present,
		input  ready
	);
	modport sink (
		input  valid, heater_temp, heater_present, ambient_dewpoint, ambient_present,
		output ready
	);
endinterface

[src/dhr_out_if.sv]
// Valid/ready channel carrying one duty result beat.
// Depends on dhr_pkg.
interface dhr_out_if import dhr_pkg::*; #(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [DUTY_BITS-1:0] duty;
	logic                 duty_changed;
	dhr_mode_t            effective_mode;
	logic                 reading_valid;
	logic                 fault_trip;

	modport source (
		output valid, duty, duty_changed, effective_mode, reading_valid, fault_trip,
		input  ready
	);
	modport sink (
		input  valid, duty, duty_changed, effective_mode, reading_valid, fault_trip,
		output ready
	);
endinterface

[src/dhr_mul.sv]
// Bit-serial multiply-accumulate: base*span + step_duty*diff, one multiplier bit a cycle.
// Depends on dhr_pkg and the assertion macro header.
`include "dew_heater_ramp_duty_controller_defines.svh"
module dhr_mul import dhr_pkg::*; #(
	parameter int TEMP_BITS = TEMP_BITS_DEF,
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [DUTY_BITS-1:0]                  base,
	input  logic [TEMP_BITS-2:0]                  span,
	input  logic signed [DUTY_BITS:0]             step_duty,
	input  logic [TEMP_BITS:0]                    diff,
	output logic signed [TEMP_BITS+DUTY_BITS+2:0] total,
	output dhr_stat_t                             stat
);
	localparam int TW = TEMP_BITS + DUTY_BITS + 3;
	localparam int PW = TEMP_BITS + 1;

	logic signed [TW-1:0] acc_q, ma_q, mb_q;
	logic [PW-1:0]        pa_q, pb_q;
	logic                 busy_q, done_q;
	logic signed [TW-1:0] add_a, add_b, acc_nxt;
	logic                 mpl_zero;

	// One partial product of each term per cycle.
	assign add_a    = pa_q[0] ? ma_q : '0;
	assign add_b    = pb_q[0] ? mb_q : '0;
	assign acc_nxt  = acc_q + add_a + add_b;
	assign mpl_zero = (pa_q == '0) && (pb_q == '0);

	// Control: run until both multipliers have shifted out to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && mpl_zero) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Shift registers and accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			ma_q  <= TW'($signed({1'b0, base}));
			mb_q  <= TW'(step_duty);
			pa_q  <= PW'(span);
			pb_q  <= diff;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			ma_q  <= ma_q <<< 1;
			mb_q  <= mb_q <<< 1;
			pa_q  <= pa_q >> 1;
			pb_q  <= pb_q >> 1;
		end
	end

	assign total     = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`DHR_ASSERT(a_mul_no_restart, start |-> !busy_q, "multiplier started while busy")
	`DHR_ASSERT(a_mul_fell_done, $fell(busy_q) |-> done_q, "multiplier stopped without done")
	`DHR_ASSERT_ALWAYS(a_mul_done_idle, done_q |-> !busy_q, "multiplier done while busy")
endmodule

[src/dhr_div.sv]
// Restoring bit-serial divider with a saturating quotient, one quotient bit a cycle.
// Depends on dhr_pkg and the assertion macro header.
`include "dew_heater_ramp_duty_controller_defines.svh"
module dhr_div import dhr_pkg::*; #(
	parameter int TEMP_BITS = TEMP_BITS_DEF,
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [TEMP_BITS+DUTY_BITS+1:0]    dividend,
	input  logic [TEMP_BITS-2:0]              divisor,
	output logic [DUTY_BITS-1:0]              quotient,
	output logic                              sat,
	output dhr_stat_t                         stat
);
	localparam int NB    = TEMP_BITS + DUTY_BITS + 2;
	localparam int RW    = TEMP_BITS - 1;
	localparam int CNT_W = $clog2(NB + 1);

	logic [NB-1:0]        dvd_q;
	logic [RW-1:0]        rem_q;
	logic [DUTY_BITS-1:0] q_q;
	logic                 sat_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q, done_q;
	logic [RW:0]          rs, rs_sub;
	logic                 ge;
	logic [RW-1:0]        rem_nxt;

	// Bring down the next dividend bit and trial-subtract the divisor.
	assign rs      = {rem_q, dvd_q[NB-1]};
	assign rs_sub  = rs - {1'b0, divisor};
	assign ge      = rs >= {1'b0, divisor};
	assign rem_nxt = ge ? rs_sub[RW-1:0] : rs[RW-1:0];

	// Control: one step per dividend bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: a one shifted out of the kept quotient bits means saturation.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt;
			q_q   <= {q_q[DUTY_BITS-2:0], ge};
			sat_q <= sat_q | q_q[DUTY_BITS-1];
		end
	end

	assign quotient  = q_q;
	assign sat       = sat_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`DHR_ASSERT(a_div_cnt_busy, busy_q |-> cnt_q != '0, "divider busy with empty count")
	`DHR_ASSERT(a_div_no_restart, start |-> !busy_q, "divider started while busy")
	`DHR_ASSERT_ALWAYS(a_div_done_idle, done_q |-> !busy_q, "divider done while busy")
endmodule

[src/dew_heater_ramp_duty_controller.sv]
// Dew heater duty controller: one duty result beat per tick beat.
// Off, fixed, latched, at-or-above target and zero-ramp ticks go from evaluation straight
// to the result; a ramp also runs the bit-serial multiply-accumulate and, for a positive
// product, the one-bit-a-cycle divider.
// One tick is in flight; the next is taken the cycle after its result is registered, even
// while that result waits. arst_n clears control and configuration state; tick and result data registers are not reset.
`include "dew_heater_ramp_duty_controller_defines.svh"
module dew_heater_ramp_duty_controller import dhr_pkg::*; #(
	parameter int TEMP_BITS = TEMP_BITS_DEF,
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_IDX_W-1:0]   wr_index,
	input  logic [((TEMP_BITS > DUTY_BITS) ? TEMP_BITS : DUTY_BITS)-1:0] wr_data,
	dhr_in_if.sink                 tick,
	dhr_out_if.source              result
);
	localparam int TW = TEMP_BITS + DUTY_BITS + 3;
	localparam int CW = ((TEMP_BITS > 11) ? TEMP_BITS : 11) + 1;
	localparam logic signed [CW-1:0] COLD_CMP = CW'(COLD_LIMIT);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EVAL = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	dhr_mode_t                   mode_q;
	logic [DUTY_BITS-1:0]        max_q, min_q;
	logic signed [TEMP_BITS-1:0] target_q, dew_ofs_q;
	logic [TEMP_BITS-2:0]        ramp_q;

	// Controller state.
	logic                 off_latch_q;
	logic [DUTY_BITS-1:0] last_duty_q;
	logic                 last_valid_q;

	// Captured tick and the result under construction.
	logic signed [TEMP_BITS-1:0] temp_q, dew_q;
	logic                        hpres_q, apres_q;
	logic [DUTY_BITS-1:0]        duty_q;
	dhr_mode_t                   res_mode_q;
	logic                        res_valid_q, res_trip_q;

	// Output register.
	logic                 out_valid_q;
	logic [DUTY_BITS-1:0] out_duty_q;
	logic                 out_changed_q, out_rvalid_q, out_trip_q;
	dhr_mode_t            out_mode_q;

	logic                        accept, fin_go;
	logic signed [CW-1:0]        temp_cmp;
	logic                        rd_valid, trip, temp_mode, diff_pos, need_mul, total_pos;
	dhr_mode_t                   eff_mode, mode_after;
	logic signed [TEMP_BITS:0]   target;
	logic signed [TEMP_BITS+1:0] diff;
	logic signed [DUTY_BITS:0]   step_duty;
	logic [DUTY_BITS-1:0]        eval_duty;
	logic                        mul_start, div_start;
	logic signed [TW-1:0]        mul_total;
	dhr_stat_t                   mul_stat, div_stat;
	logic [DUTY_BITS-1:0]        div_q;
	logic                        div_sat;

	assign tick.ready = (state_q == S_IDLE);
	assign accept     = tick.valid && tick.ready;
	assign fin_go     = (state_q == S_FIN) && (!out_valid_q || result.ready);

	// Tick evaluation: reading check, latch decision and ramp setpoint.
	assign temp_cmp   = CW'(temp_q);
	assign rd_valid   = hpres_q && (temp_cmp >= COLD_CMP);
	assign eff_mode   = off_latch_q ? MODE_OFF : mode_q;
	assign temp_mode  = (eff_mode == MODE_DEW) || (eff_mode == MODE_TARGET);
	assign trip       = temp_mode && (!rd_valid || ((eff_mode == MODE_DEW) && !apres_q));
	assign mode_after = trip ? MODE_OFF : eff_mode;
	assign target     = (eff_mode == MODE_DEW) ?
	                    ((TEMP_BITS+1)'(dew_q) + (TEMP_BITS+1)'(dew_ofs_q)) :
	                    (TEMP_BITS+1)'(target_q);
	assign diff       = (TEMP_BITS+2)'(target) - (TEMP_BITS+2)'(temp_q);
	assign diff_pos   = !diff[TEMP_BITS+1] && (diff != '0);
	assign need_mul   = ((mode_after == MODE_DEW) || (mode_after == MODE_TARGET)) &&
	                    diff_pos && (ramp_q != '0);
	assign step_duty  = $signed({1'b0, max_q}) - $signed({1'b0, min_q});

	// Duty known at evaluation; a ramp overwrites it later.
	always_comb begin
		case (mode_after)
			MODE_FIXED:  eval_duty = max_q;
			MODE_DEW,
			MODE_TARGET: eval_duty = diff_pos ? max_q : '0;
			default:     eval_duty = '0;
		endcase
	end

	assign mul_start = (state_q == S_EVAL) && need_mul;
	assign total_pos = !mul_total[TW-1] && (mul_total != '0);
	assign div_start = (state_q == S_MUL) && mul_stat.done && total_pos;

	dhr_mul #(
		.TEMP_BITS(TEMP_BITS),
		.DUTY_BITS(DUTY_BITS)
	) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_start),
		.base     (min_q),
		.span     (ramp_q),
		.step_duty(step_duty),
		.diff     (diff[TEMP_BITS:0]),
		.total    (mul_total),
		.stat     (mul_stat)
	);

	dhr_div #(
		.TEMP_BITS(TEMP_BITS),
		.DUTY_BITS(DUTY_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mul_total[TW-2:0]),
		.divisor (ramp_q),
		.quotient(div_q),
		.sat     (div_sat),
		.stat    (div_stat)
	);

	// Sequencer, configuration writes and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= MODE_OFF;
			max_q        <= '0;
			min_q        <= '0;
			target_q     <= '0;
			dew_ofs_q    <= '0;
			ramp_q       <= '0;
			off_latch_q  <= 1'b0;
			last_duty_q  <= '0;
			last_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (trip) begin
						off_latch_q <= 1'b1;
					end
					state_q <= need_mul ? S_MUL : S_FIN;
				end
				S_MUL: begin
					if (mul_stat.done) begin
						state_q <= total_pos ? S_DIV : S_FIN;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q      <= S_IDLE;
						last_duty_q  <= duty_q;
						last_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (wr_en) begin
				case (wr_index)
					REG_MODE: begin
						mode_q      <= dhr_mode_t'(wr_data[1:0]);
						off_latch_q <= 1'b0;
					end
					REG_MAX_DUTY: max_q     <= wr_data[DUTY_BITS-1:0];
					REG_MIN_DUTY: min_q     <= wr_data[DUTY_BITS-1:0];
					REG_TARGET:   target_q  <= $signed(wr_data[TEMP_BITS-1:0]);
					REG_DEW_OFS:  dew_ofs_q <= $signed(wr_data[TEMP_BITS-1:0]);
					REG_RAMP:     ramp_q    <= wr_data[TEMP_BITS-2:0];
					default: ;
				endcase
			end
		end
	end

	// Tick capture, result building and the output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			temp_q  <= tick.heater_temp;
			hpres_q <= tick.heater_present;
			dew_q   <= tick.ambient_dewpoint;
			apres_q <= tick.ambient_present;
		end
		if (state_q == S_EVAL) begin
			duty_q      <= eval_duty;
			res_mode_q  <= mode_after;
			res_valid_q <= rd_valid;
			res_trip_q  <= trip;
		end
		if ((state_q == S_MUL) && mul_stat.done && !total_pos) begin
			duty_q <= '0;
		end
		if ((state_q == S_DIV) && div_stat.done) begin
			duty_q <= div_sat ? '1 : div_q;
		end
		if (fin_go) begin
			out_duty_q    <= duty_q;
			out_changed_q <= !last_valid_q || (duty_q != last_duty_q);
			out_mode_q    <= res_mode_q;
			out_rvalid_q  <= res_valid_q;
			out_trip_q    <= res_trip_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.duty           = out_duty_q;
	assign result.duty_changed   = out_changed_q;
	assign result.effective_mode = out_mode_q;
	assign result.reading_valid  = out_rvalid_q;
	assign result.fault_trip     = out_trip_q;

	`DHR_ASSERT(a_trip_off, result.valid && result.fault_trip |-> result.effective_mode == MODE_OFF && result.duty == '0, "trip beat not off")
	`DHR_ASSERT(a_latch_trip, $rose(off_latch_q) |-> res_trip_q, "latch set without trip")
	`DHR_ASSERT(a_mul_done_state, mul_stat.done |-> state_q == S_MUL, "multiplier done out of sequence")
	`DHR_ASSERT(a_div_done_state, div_stat.done |-> state_q == S_DIV, "divider done out of sequence")
endmodule
